@@ hw/rtl/rgb9e5_pkg.sv @@
// Package for the RGB9E5 pixel codec: payload types, opcodes, constants.
// Depends on nothing.
`default_nettype none
package rgb9e5_pkg;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] red_in;
        logic [31:0] green_in;
        logic [31:0] blue_in;
        logic [31:0] packed_in;
    } t_in_word;

    typedef struct packed {
        logic [31:0] packed_out;
        logic [31:0] red_out;
        logic [31:0] green_out;
        logic [31:0] blue_out;
    } t_out_word;

    localparam logic [31:0] CLAMP_BITS = 32'h477F_8000;
    localparam logic [8:0]  MANT_MAX   = 9'd511;

endpackage
`default_nettype wire

@@ hw/rtl/rgb9e5_enc_mant.sv @@
// Mantissa encoder for one clamped channel given the shared exponent.
// Depends on rgb9e5_pkg.
`default_nettype none
module rgb9e5_enc_mant (
    input  wire logic [31:0] i_bits,
    input  wire logic [4:0]  i_exp,
    output logic      [8:0]  o_mant
);
    logic [7:0]  fexp;
    logic [23:0] mant;
    logic [9:0]  sh;      // signed shift = f - 126 - e (or -125 - e)
    logic [5:0]  n;
    logic [33:0] sum;
    logic [33:0] v;

    always_comb begin
        fexp = i_bits[30:23];
        mant = {(fexp != 8'd0), i_bits[22:0]};
        if (fexp == 8'd0) begin
            sh = 10'd1 - 10'd126 - {5'd0, i_exp};
        end else begin
            sh = {2'd0, fexp} - 10'd126 - {5'd0, i_exp};
        end
        n   = 6'd0;
        sum = 34'd0;
        v   = 34'd0;
        o_mant = 9'd0;
        if (mant == 24'd0) begin
            o_mant = 9'd0;
        end else if (!sh[9]) begin
            if ($signed(sh) > 10'sd9) begin
                o_mant = rgb9e5_pkg::MANT_MAX;
            end else begin
                v = {10'd0, mant} << sh[3:0];
                o_mant = (v > 34'd511) ? rgb9e5_pkg::MANT_MAX : v[8:0];
            end
        end else if ($signed(sh) > -10'sd34) begin
            n   = 6'((~sh) + 10'd1);
            sum = {10'd0, mant} + (34'd1 << (n - 6'd1));
            v   = sum >> n;
            o_mant = (v > 34'd511) ? rgb9e5_pkg::MANT_MAX : v[8:0];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/rgb9e5_dec_chan.sv @@
// Decodes one 9-bit mantissa and shared exponent to float bits.
// Depends on nothing outside this file.
`default_nettype none
module rgb9e5_dec_chan (
    input  wire logic [8:0]  i_mant,
    input  wire logic [4:0]  i_exp,
    output logic      [31:0] o_bits
);
    logic [3:0]  p;
    logic [22:0] frac;
    logic [7:0]  bexp;

    always_comb begin
        p = 4'd0;
        for (int k = 1; k < 9; k++) begin
            if (i_mant[k]) p = 4'(k);
        end
        frac = 23'({i_mant, 14'd0} << (4'd9 - p));
        bexp = 8'({4'd0, p}) + {3'd0, i_exp} + 8'd103;
        o_bits = (i_mant == 9'd0) ? 32'd0 : {1'b0, bexp, frac};
    end
endmodule
`default_nettype wire

@@ hw/rtl/rgb9e5_shared_exponent_codec_core.sv @@
// RGB9E5 shared-exponent codec: float RGB to packed word and back.
// Each accepted input word is registered in r_in and its result in r_out.
// Throughput: one word per cycle while i_stall and o_stall are low; under
// output stall the skid slot parks one computed word, then o_stall holds input.
// Reset: synchronous active-low i_rst_n clears all valid flags.
`default_nettype none
module rgb9e5_shared_exponent_codec_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire rgb9e5_pkg::t_in_word  i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output rgb9e5_pkg::t_out_word      o_data
);
    // Input register stage.
    logic                  r_in_valid;
    rgb9e5_pkg::t_in_word  r_in;
    // Output register plus skid slot.
    logic                  r_out_valid, r_skid_valid;
    rgb9e5_pkg::t_out_word r_out, r_skid;
    rgb9e5_pkg::t_out_word n_res;

    // Stall input whenever the skid slot is occupied.
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    logic [31:0] cr, cg, cb, mx;
    logic [8:0]  fe;
    logic [4:0]  e;
    logic [8:0]  mr, mg, mb;
    logic [31:0] dr, dg, db;

    function automatic logic [31:0] clamp_ch(input logic [31:0] b);
        logic [31:0] r;
        if (b[31]) r = 32'd0;
        else if (b[30:23] == 8'hFF && b[22:0] != 23'd0) r = 32'd0;
        else if (b > rgb9e5_pkg::CLAMP_BITS) r = rgb9e5_pkg::CLAMP_BITS;
        else r = b;
        return r;
    endfunction

    always_comb begin
        cr = clamp_ch(r_in.red_in);
        cg = clamp_ch(r_in.green_in);
        cb = clamp_ch(r_in.blue_in);
        mx = cr;
        if (cg > mx) mx = cg;
        if (cb > mx) mx = cb;
        // Biased exponent minus 111, floored at zero; clamp keeps it <= 31.
        fe = {1'b0, mx[30:23]} - 9'd111;
        e  = fe[8] ? 5'd0 : fe[4:0];
    end

    rgb9e5_enc_mant u_enc_r (.i_bits(cr), .i_exp(e), .o_mant(mr));
    rgb9e5_enc_mant u_enc_g (.i_bits(cg), .i_exp(e), .o_mant(mg));
    rgb9e5_enc_mant u_enc_b (.i_bits(cb), .i_exp(e), .o_mant(mb));

    rgb9e5_dec_chan u_dec_r (.i_mant(r_in.packed_in[8:0]),
                             .i_exp(r_in.packed_in[31:27]), .o_bits(dr));
    rgb9e5_dec_chan u_dec_g (.i_mant(r_in.packed_in[17:9]),
                             .i_exp(r_in.packed_in[31:27]), .o_bits(dg));
    rgb9e5_dec_chan u_dec_b (.i_mant(r_in.packed_in[26:18]),
                             .i_exp(r_in.packed_in[31:27]), .o_bits(db));

    always_comb begin
        n_res = '0;
        if (r_in.opcode == rgb9e5_pkg::OP_ENCODE) begin
            n_res.packed_out = {e, mb, mg, mr};
        end else begin
            n_res.red_out   = dr;
            n_res.green_out = dg;
            n_res.blue_out  = db;
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            // Advance the output register; drain skid first.
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= n_res;
                    r_out_valid <= r_in_valid;
                end
            end else if (r_in_valid && !r_skid_valid) begin
                // Output held: park the computed word in the skid slot.
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
            // Input stage: the computed word always leaves (out or skid) unless skid busy.
            if (!r_skid_valid) begin
                r_in_valid <= i_valid;
                r_in       <= i_data;
            end else if (out_free) begin
                // Skid drains into output; input word still held in r_in.
                r_in_valid <= r_in_valid;
            end
        end
    end
endmodule
`default_nettype wire
